FILE: rtl/core/adcv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adcv_pkg: breakpoint table and shared types
// Holds the fixed code/voltage breakpoint table of the converter curve and
// the payload types that travel between the pipeline stages.
// ============================================================================
package adcv_pkg;

    localparam int NUM_POINTS = 25;
    localparam int X_W        = 12;
    localparam int CODE_W     = 13;
    localparam int VOLT_W     = 6;
    localparam int OUT_W      = 14;
    localparam int OUT_MAX    = 16383;
    localparam int SEG_DW     = $clog2(NUM_POINTS + 1);
    localparam int SEG_IW     = $clog2(NUM_POINTS);
    localparam int PROD_W     = X_W + VOLT_W;

    localparam logic [CODE_W-1:0] BP_CODE [NUM_POINTS] = '{
        13'h0000, 13'h0468, 13'h04C0, 13'h050A, 13'h055A, 13'h05A8, 13'h05FC,
        13'h0643, 13'h0690, 13'h06E0, 13'h0730, 13'h0782, 13'h07CA, 13'h081F,
        13'h0868, 13'h08B3, 13'h0902, 13'h094F, 13'h099F, 13'h09E5, 13'h0A39,
        13'h0A7C, 13'h0AD0, 13'h0B1F, 13'h1000
    };

    localparam logic [VOLT_W-1:0] BP_VOLT [NUM_POINTS] = '{
        6'd0,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16,
        6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd48
    };

    typedef struct packed {
        logic              special;
        logic [VOLT_W-1:0] spec_v;
        logic [VOLT_W-1:0] lo_v;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [VOLT_W-1:0] dv;
        logic [CODE_W-1:0] den;
        logic [X_W-1:0]    dx;
    } seg_t;

endpackage
`default_nettype wire

FILE: rtl/core/adcv_seg_find.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adcv_seg_find: segment search
// Three stages: compare the code against every breakpoint, encode the
// segment index, then fetch the segment ends and form the offsets.
// ============================================================================
module adcv_seg_find
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   valid_in,
    input  wire logic [adcv_pkg::X_W-1:0] code_in,
    output logic                        valid_out,
    output adcv_pkg::seg_t              seg_out
);
    import adcv_pkg::*;

    logic [2:0]            valid_reg;
    logic [X_W-1:0]        x1_reg;
    logic [NUM_POINTS-1:0] gt1_reg;
    logic [NUM_POINTS-1:0] gt1_next;
    logic [X_W-1:0]        x2_reg;
    logic [SEG_DW-1:0]     d2_reg;
    logic [SEG_DW-1:0]     d2_next;
    logic                  found;
    seg_t                  seg3_reg;
    seg_t                  seg3_next;
    logic [SEG_IW-1:0]     lo_idx;
    logic [SEG_IW-1:0]     hi_idx;
    logic [CODE_W-1:0]     lo_a;
    logic [CODE_W-1:0]     hi_a;
    logic [VOLT_W-1:0]     lo_v;
    logic [VOLT_W-1:0]     hi_v;
    logic [CODE_W-1:0]     dx_full;

    always_comb
    begin
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            gt1_next[i] = {1'b0, code_in} > BP_CODE[i];
        end
    end

    always_comb
    begin
        d2_next = SEG_DW'(NUM_POINTS);
        found   = 1'b0;
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            if (!found && !gt1_reg[i])
            begin
                d2_next = SEG_DW'(i);
                found   = 1'b1;
            end
        end
    end

    always_comb
    begin
        lo_idx    = SEG_IW'(d2_reg - SEG_DW'(1));
        hi_idx    = SEG_IW'(d2_reg);
        lo_a      = '0;
        hi_a      = '0;
        lo_v      = '0;
        hi_v      = '0;
        dx_full   = '0;
        seg3_next = '0;
        seg3_next.den = CODE_W'(1);
        priority if (d2_reg == '0)
        begin
            seg3_next.side.special = 1'b1;
            seg3_next.side.spec_v  = BP_VOLT[0];
        end
        else if (d2_reg == SEG_DW'(NUM_POINTS))
        begin
            seg3_next.side.special = 1'b1;
            seg3_next.side.spec_v  = BP_VOLT[NUM_POINTS-1];
        end
        else
        begin
            lo_a = BP_CODE[lo_idx];
            hi_a = BP_CODE[hi_idx];
            lo_v = BP_VOLT[lo_idx];
            hi_v = BP_VOLT[hi_idx];
            if (hi_a <= lo_a || hi_v < lo_v)
            begin
                seg3_next.side.special = 1'b1;
                seg3_next.side.spec_v  = hi_v;
            end
            else
            begin
                dx_full             = {1'b0, x2_reg} - lo_a;
                seg3_next.side.lo_v = lo_v;
                seg3_next.dv        = hi_v - lo_v;
                seg3_next.den       = hi_a - lo_a;
                seg3_next.dx        = dx_full[X_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[1:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg   <= code_in;
            gt1_reg  <= gt1_next;
            x2_reg   <= x1_reg;
            d2_reg   <= d2_next;
            seg3_reg <= seg3_next;
        end
    end

    assign valid_out = valid_reg[2];
    assign seg_out   = seg3_reg;

endmodule
`default_nettype wire

FILE: rtl/core/adcv_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adcv_div_stage: one restoring division step
// Brings down the next numerator bit, subtracts the segment width where it
// fits and shifts one quotient bit in.
// ============================================================================
module adcv_div_stage
#(
    parameter int QW = 14
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        valid_in,
    input  wire adcv_pkg::side_t             side_in,
    input  wire logic [adcv_pkg::CODE_W-1:0] den_in,
    input  wire logic [adcv_pkg::CODE_W-1:0] rem_in,
    input  wire logic [QW-1:0]               nlo_in,
    input  wire logic [QW-1:0]               q_in,
    output logic                             valid_out,
    output adcv_pkg::side_t                  side_out,
    output logic [adcv_pkg::CODE_W-1:0]      den_out,
    output logic [adcv_pkg::CODE_W-1:0]      rem_out,
    output logic [QW-1:0]                    nlo_out,
    output logic [QW-1:0]                    q_out
);
    import adcv_pkg::*;

    logic                valid_reg;
    side_t               side_reg;
    logic [CODE_W-1:0]   den_reg;
    logic [CODE_W-1:0]   rem_reg;
    logic [CODE_W-1:0]   rem_next;
    logic [QW-1:0]       nlo_reg;
    logic [QW-1:0]       q_reg;
    logic [CODE_W:0]     trial;
    logic [CODE_W:0]     diff;
    logic                fits;

    always_comb
    begin
        trial    = {rem_in, nlo_in[QW-1]};
        fits     = trial >= {1'b0, den_in};
        diff     = trial - {1'b0, den_in};
        rem_next = fits ? diff[CODE_W-1:0] : trial[CODE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg <= side_in;
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            nlo_reg  <= {nlo_in[QW-2:0], 1'b0};
            q_reg    <= {q_in[QW-2:0], fits};
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign den_out   = den_reg;
    assign rem_out   = rem_reg;
    assign nlo_out   = nlo_reg;
    assign q_out     = q_reg;

endmodule
`default_nettype wire

FILE: rtl/core/adc_code_to_voltage_interp.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adc_code_to_voltage_interp: ADC code to voltage by linear interpolation
// Finds the breakpoint segment of a 12-bit code and interpolates the voltage
// between its ends, giving volts with FRAC_BITS fraction bits, truncated.
//
//   Channel   Handshake            Payload
//   input     in_valid/in_ready    adc_code  [11:0]
//   output    out_valid/out_ready  volts_q8  [13:0]
//
// One beat enters per cycle while in_ready is high; the pipeline is three
// search stages, one multiply stage, one divider stage per quotient bit
// (FRAC_BITS + 6) and the output register.
// Reset clears only the stage valid bits.
// A stall at the output freezes every stage together; in_ready is low only
// while the output beat is held.
// ============================================================================
module adc_code_to_voltage_interp
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [adcv_pkg::X_W-1:0]     adc_code,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [adcv_pkg::OUT_W-1:0]        volts_q8
);
    import adcv_pkg::*;

    localparam int QW = VOLT_W + FRAC_BITS;
    localparam int NW = PROD_W + FRAC_BITS;
    localparam int RW = QW + 1;

    logic              adv;
    logic              s_valid;
    seg_t              s_seg;
    logic              m_valid_reg;
    side_t             m_side_reg;
    logic [CODE_W-1:0] m_den_reg;
    logic [PROD_W-1:0] m_prod_reg;
    logic [PROD_W-1:0] m_prod_next;
    logic [NW-1:0]     m_num;

    logic              d_valid [QW+1];
    side_t             d_side  [QW+1];
    logic [CODE_W-1:0] d_den   [QW+1];
    logic [CODE_W-1:0] d_rem   [QW+1];
    logic [QW-1:0]     d_nlo   [QW+1];
    logic [QW-1:0]     d_q     [QW+1];

    logic              out_valid_reg;
    logic [OUT_W-1:0]  volts_reg;
    logic [OUT_W-1:0]  volts_next;
    logic [RW-1:0]     res;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    adcv_seg_find u_seg_find
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (in_valid),
        .code_in   (adc_code),
        .valid_out (s_valid),
        .seg_out   (s_seg)
    );

    assign m_prod_next = PROD_W'(s_seg.dx) * PROD_W'(s_seg.dv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_side_reg <= s_seg.side;
            m_den_reg  <= s_seg.den;
            m_prod_reg <= m_prod_next;
        end
    end

    assign m_num    = NW'(m_prod_reg) << FRAC_BITS;
    assign d_valid[0] = m_valid_reg;
    assign d_side[0]  = m_side_reg;
    assign d_den[0]   = m_den_reg;
    assign d_rem[0]   = CODE_W'(m_num[NW-1:QW]);
    assign d_nlo[0]   = m_num[QW-1:0];
    assign d_q[0]     = '0;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        adcv_div_stage #(.QW(QW)) u_div_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (d_valid[k]),
            .side_in   (d_side[k]),
            .den_in    (d_den[k]),
            .rem_in    (d_rem[k]),
            .nlo_in    (d_nlo[k]),
            .q_in      (d_q[k]),
            .valid_out (d_valid[k+1]),
            .side_out  (d_side[k+1]),
            .den_out   (d_den[k+1]),
            .rem_out   (d_rem[k+1]),
            .nlo_out   (d_nlo[k+1]),
            .q_out     (d_q[k+1])
        );
    end

    always_comb
    begin
        if (d_side[QW].special)
        begin
            res = RW'(d_side[QW].spec_v) << FRAC_BITS;
        end
        else
        begin
            res = (RW'(d_side[QW].lo_v) << FRAC_BITS) + RW'(d_q[QW]);
        end
        if (32'(res) > 32'(OUT_MAX))
        begin
            volts_next = OUT_W'(OUT_MAX);
        end
        else
        begin
            volts_next = OUT_W'(res);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            volts_reg <= volts_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign volts_q8  = volts_reg;

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready))
        else $error("pipeline stalled without a held output beat");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_side_reg.special) |-> (m_den_reg != '0))
        else $error("zero segment width reached the divider");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid[QW] && !d_side[QW].special) |-> (d_rem[QW] < d_den[QW]))
        else $error("division remainder not below segment width");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid[QW] && !adv) |=> d_valid[QW])
        else $error("divider beat dropped during stall");

endmodule
`default_nettype wire

FILE: tb/adc_code_to_voltage_interp_test.sv
`timescale 1ns / 1ps
// ============================================================================
// adc_code_to_voltage_interp_test: self-checking bench for the code converter
// Streams 12-bit ADC codes through the interpolator under varying sender
// gaps and receiver stalls, predicts every voltage from its own copy of the
// breakpoint curve and compares each output beat in order.
// ============================================================================
module adc_code_to_voltage_interp_test;

    localparam int CURVE_POINTS = 25;
    localparam int FRAC         = 8;
    localparam int VOLTS_MAX    = 16383;
    localparam int PIPE_DEPTH   = FRAC + 11;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [12:0] CURVE_CODE [CURVE_POINTS] = '{
        13'h0000, 13'h0468, 13'h04C0, 13'h050A, 13'h055A, 13'h05A8, 13'h05FC,
        13'h0643, 13'h0690, 13'h06E0, 13'h0730, 13'h0782, 13'h07CA, 13'h081F,
        13'h0868, 13'h08B3, 13'h0902, 13'h094F, 13'h099F, 13'h09E5, 13'h0A39,
        13'h0A7C, 13'h0AD0, 13'h0B1F, 13'h1000
    };

    localparam logic [5:0] CURVE_VOLT [CURVE_POINTS] = '{
        6'd0,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16,
        6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd48
    };

    localparam logic [11:0] DIRECTED_CODES [18] = '{
        12'h000, 12'h001, 12'h467, 12'h468, 12'h469, 12'h4C0, 12'h50A,
        12'h7CA, 12'hA7C, 12'hAD0, 12'hB1E, 12'hB1F, 12'hB20, 12'h800,
        12'hAAA, 12'h555, 12'hFFE, 12'hFFF
    };

    typedef struct {
        logic [adcv_pkg::X_W-1:0]   code;
        logic [adcv_pkg::OUT_W-1:0] volts;
    } conv_beat_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic [adcv_pkg::X_W-1:0]     adc_code  = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [adcv_pkg::OUT_W-1:0]   volts_q8;

    logic [adcv_pkg::X_W-1:0] code_queue [$];
    conv_beat_t               volts_expected [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int hold_trigger  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    adc_code_to_voltage_interp dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .adc_code  (adc_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .volts_q8  (volts_q8)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [adcv_pkg::OUT_W-1:0] interp_volts(
        input logic [adcv_pkg::X_W-1:0] code);
        int              seg;
        longint unsigned lo_a, hi_a, lo_v, hi_v, span, res;
        begin
            seg = 0;
            for (int i = 0; i < CURVE_POINTS; i++)
                if (seg == i && {1'b0, code} > CURVE_CODE[i])
                    seg = i + 1;
            if (seg == 0)
                res = longint'(CURVE_VOLT[0]) << FRAC;
            else if (seg >= CURVE_POINTS)
                res = longint'(CURVE_VOLT[CURVE_POINTS-1]) << FRAC;
            else
            begin
                lo_a = CURVE_CODE[seg-1];
                hi_a = CURVE_CODE[seg];
                lo_v = CURVE_VOLT[seg-1];
                hi_v = CURVE_VOLT[seg];
                if (hi_a <= lo_a || hi_v < lo_v)
                    res = hi_v << FRAC;
                else
                begin
                    span = ((longint'(code) - lo_a) * (hi_v - lo_v)) << FRAC;
                    res  = (lo_v << FRAC) + span / (hi_a - lo_a);
                end
            end
            if (res > VOLTS_MAX)
                res = VOLTS_MAX;
            return res[adcv_pkg::OUT_W-1:0];
        end
    endfunction

    // bias towards the breakpoints so every segment edge gets hit
    function automatic logic [adcv_pkg::X_W-1:0] pick_code();
        int          idx;
        logic [12:0] knee;
        begin
            if ($urandom_range(3) == 0)
            begin
                idx  = $urandom_range(CURVE_POINTS - 2);
                knee = CURVE_CODE[idx] + 13'($urandom_range(2)) - 13'd1;
                return knee[adcv_pkg::X_W-1:0];
            end
            return adcv_pkg::X_W'($urandom);
        end
    endfunction

    always @(posedge clk)
    begin : drive_blk
        conv_beat_t beat;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                beat.code  = adc_code;
                beat.volts = interp_volts(adc_code);
                volts_expected.push_back(beat);
            end
            if (!in_valid || in_ready)
            begin
                if (code_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    adc_code <= code_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_trigger != hold_seen)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_trigger;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_left != 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : check_blk
        conv_beat_t beat;
        if (rst_n && out_valid && out_ready)
        begin
            if (volts_expected.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected beat: expected none, got volts_q8 %0d",
                         $time, volts_q8);
            end
            else
            begin
                beat = volts_expected.pop_front();
                if (volts_q8 !== beat.volts)
                begin
                    fail_count++;
                    $display("%0t: volts_q8 for code 0x%03h: expected %0d, got %0d",
                             $time, beat.code, beat.volts, volts_q8);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("adc_code_to_voltage_interp_test NOT OK");
            $finish;
        end
    end

    task automatic wait_drained();
        while (code_queue.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        begin
            send_idle_pct = idle;
            stall_pct     = stall;
            for (int k = 0; k < count; k++)
                code_queue.push_back(pick_code());
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_CODES[i])
            code_queue.push_back(DIRECTED_CODES[i]);
        wait_drained();

        run_phase(0, 0, 300);
        run_phase(80, 0, 300);
        run_phase(0, 80, 300);
        run_phase(16, 16, 400);

        hold_trigger = hold_trigger + 1;
        run_phase(0, 0, 200);

        stall_pct = 0;
        while (volts_expected.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH + 10) @(posedge clk);

        if (fail_count == 0 && volts_expected.size() == 0)
            $display("adc_code_to_voltage_interp_test OK");
        else
            $display("adc_code_to_voltage_interp_test NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/adcv_pkg.sv
rtl/core/adcv_seg_find.sv
rtl/core/adcv_div_stage.sv
rtl/core/adc_code_to_voltage_interp.sv
tb/adc_code_to_voltage_interp_test.sv
